@@ rtl/rsacm_pkg.sv @@
`timescale 1ns / 1ps
package rsacm_pkg;

	localparam int MOD_WIDTH  = 32;
	localparam int STEP_W     = $clog2(MOD_WIDTH);
	localparam int CODED_W    = MOD_WIDTH + 1;
	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;

	localparam logic [1:0] REG_MODULUS  = 2'd0;
	localparam logic [1:0] REG_ENC_EXP  = 2'd1;
	localparam logic [1:0] REG_DEC_EXP  = 2'd2;

	localparam logic [MOD_WIDTH-1:0] MODULUS_RST = MOD_WIDTH'(3233);
	localparam logic [MOD_WIDTH-1:0] ENC_EXP_RST = MOD_WIDTH'(17);
	localparam logic [MOD_WIDTH-1:0] DEC_EXP_RST = MOD_WIDTH'(2753);

	localparam logic       OP_ENCRYPT  = 1'b0;
	localparam logic       OP_DECRYPT  = 1'b1;
	localparam logic [7:0] CHAR_OFFSET = 8'd96;

	typedef struct packed {
		logic                 start;
		logic [MOD_WIDTH-1:0] a;
		logic [MOD_WIDTH-1:0] b;
	} mm_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [MOD_WIDTH-1:0] product;
	} mm_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED_GO,
		ST_RED_WAIT,
		ST_EXP_CHECK,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_SQ_GO,
		ST_SQ_WAIT,
		ST_FINISH
	} state_t;

endpackage

@@ rtl/rsacm_modmul.sv @@
`timescale 1ns / 1ps
module rsacm_modmul
	import rsacm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  mm_req_t              req,
	input  logic [MOD_WIDTH:0]   n,
	output mm_rsp_t              rsp
);

	logic [MOD_WIDTH-1:0] r_q;
	logic [MOD_WIDTH-1:0] a_q;
	logic [MOD_WIDTH-1:0] b_q;
	logic [STEP_W-1:0]    cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [MOD_WIDTH:0]   dbl;
	logic [MOD_WIDTH:0]   dbl_red;
	logic [MOD_WIDTH+1:0] sum;
	logic [MOD_WIDTH+1:0] sum_red;
	logic [MOD_WIDTH-1:0] r_next;

	// one multiplier bit per cycle, MSB first: r = 2r mod n, then r = r + a mod n if the bit is set
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= n) ? dbl - n : dbl;
		sum     = {1'b0, dbl_red} + {2'b00, a_q};
		sum_red = (sum >= {1'b0, n}) ? sum - {1'b0, n} : sum;
		r_next  = b_q[MOD_WIDTH-1] ? sum_red[MOD_WIDTH-1:0] : dbl_red[MOD_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(MOD_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q <= '0;
			a_q <= req.a;
			b_q <= req.b;
		end else if (busy_q) begin
			r_q <= r_next;
			b_q <= {b_q[MOD_WIDTH-2:0], 1'b0};
		end
	end

	assign rsp.busy    = busy_q;
	assign rsp.done    = done_q;
	assign rsp.product = r_q;

endmodule

@@ rtl/rsa_char_modexp_cipher.sv @@
`timescale 1ns / 1ps
// Character RSA cipher: modular exponentiation of one item at a time.
// Input channel (in_valid/in_ready) carries operation, data_in and
// end_of_message. Encrypt raises ((data_in - 96) & 0xff) to the encrypt
// exponent; decrypt raises data_in to the decrypt exponent; both mod modulus.
// Output channel (out_valid/out_ready) carries residue, coded_value and
// end_of_message_out, one result per item, from an output register.
// Registers sit on the APB port: modulus at 0x0, encrypt exponent at 0x4,
// decrypt exponent at 0x8; write them only while the block is idle.
// One bit-serial modular multiplier does all the work. An item takes one
// reduction of the base, one multiply per set exponent bit and one square
// per exponent bit below the top one, plus one check step per exponent
// bit. The sequencer returns to idle, with in_ready high, as the result
// enters the output register and out_valid rises.
// in_ready is high only while the sequencer is idle, so one item is in flight.
// If the receiver stalls, the finished result waits in the output register
// and a new item may already be taken; the next result then waits until the
// register is free. Reset clears all valids and loads the default key
// (modulus 3233, exponents 17 and 2753).
module rsa_char_modexp_cipher
	import rsacm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic [MOD_WIDTH-1:0] data_in,
	input  logic                 end_of_message,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [MOD_WIDTH-1:0] residue,
	output logic [CODED_W-1:0]   coded_value,
	output logic                 end_of_message_out
);

	logic [MOD_WIDTH-1:0] modulus_q;
	logic [MOD_WIDTH-1:0] enc_exp_q;
	logic [MOD_WIDTH-1:0] dec_exp_q;

	state_t               state_q;
	state_t               state_d;

	logic [MOD_WIDTH-1:0] base_q;
	logic [MOD_WIDTH-1:0] result_q;
	logic [MOD_WIDTH-1:0] exp_q;
	logic                 op_q;
	logic                 eom_q;

	logic                 out_valid_q;
	logic [MOD_WIDTH-1:0] residue_q;
	logic [CODED_W-1:0]   coded_q;
	logic                 eom_out_q;

	logic [MOD_WIDTH:0]   n_ext;
	logic [MOD_WIDTH-1:0] plain;
	logic [MOD_WIDTH-1:0] exp_shr;
	logic                 in_acc;
	logic                 out_free;
	logic                 cfg_wr;
	mm_req_t              mm_req;
	mm_rsp_t              mm_rsp;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RST;
			enc_exp_q <= ENC_EXP_RST;
			dec_exp_q <= DEC_EXP_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MODULUS: modulus_q <= pwdata;
				REG_ENC_EXP: enc_exp_q <= pwdata;
				REG_DEC_EXP: dec_exp_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MODULUS: prdata = modulus_q;
			REG_ENC_EXP: prdata = enc_exp_q;
			REG_DEC_EXP: prdata = dec_exp_q;
			default:     prdata = '0;
		endcase
	end

	// a zero modulus stands for 2^MOD_WIDTH: plain wrapping arithmetic
	assign n_ext = (modulus_q == '0) ? {1'b1, {MOD_WIDTH{1'b0}}} : {1'b0, modulus_q};

	assign plain    = {{(MOD_WIDTH-8){1'b0}}, data_in[7:0] - CHAR_OFFSET};
	assign exp_shr  = {1'b0, exp_q[MOD_WIDTH-1:1]};
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	rsacm_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.n      (n_ext),
		.rsp    (mm_rsp)
	);

	// Sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (in_valid) state_d = ST_RED_GO;
			ST_RED_GO:    state_d = ST_RED_WAIT;
			ST_RED_WAIT:  if (mm_rsp.done) state_d = ST_EXP_CHECK;
			ST_EXP_CHECK: begin
				if (exp_q == '0) state_d = ST_FINISH;
				else if (exp_q[0]) state_d = ST_MUL_GO;
				else state_d = ST_SQ_GO;
			end
			ST_MUL_GO:    state_d = ST_MUL_WAIT;
			ST_MUL_WAIT: begin
				if (mm_rsp.done) state_d = (exp_shr != '0) ? ST_SQ_GO : ST_FINISH;
			end
			ST_SQ_GO:     state_d = ST_SQ_WAIT;
			ST_SQ_WAIT:   if (mm_rsp.done) state_d = ST_EXP_CHECK;
			ST_FINISH:    if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Sequencer: outputs
	always_comb begin
		in_ready     = 1'b0;
		mm_req.start = 1'b0;
		mm_req.a     = base_q;
		mm_req.b     = base_q;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_RED_GO: begin
				// base mod n as 1 * base
				mm_req.start = 1'b1;
				mm_req.a     = MOD_WIDTH'(1);
			end
			ST_MUL_GO: begin
				mm_req.start = 1'b1;
				mm_req.a     = result_q;
			end
			ST_SQ_GO:  mm_req.start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FINISH && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					op_q     <= operation;
					eom_q    <= end_of_message;
					result_q <= MOD_WIDTH'(1);
					base_q   <= (operation == OP_ENCRYPT) ? plain : data_in;
					exp_q    <= (operation == OP_ENCRYPT) ? enc_exp_q : dec_exp_q;
				end
			end
			ST_RED_WAIT, ST_SQ_WAIT: if (mm_rsp.done) base_q <= mm_rsp.product;
			ST_EXP_CHECK: if (exp_q != '0 && !exp_q[0]) exp_q <= exp_shr;
			ST_MUL_WAIT: begin
				if (mm_rsp.done) begin
					result_q <= mm_rsp.product;
					exp_q    <= exp_shr;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					residue_q <= result_q;
					eom_out_q <= eom_q;
					if (op_q == OP_DECRYPT)
						coded_q <= {{(CODED_W-8){1'b0}}, result_q[7:0]}
							+ CODED_W'(CHAR_OFFSET);
					else
						coded_q <= {1'b0, result_q} + CODED_W'(CHAR_OFFSET);
				end
			end
			default: ;
		endcase
	end

	assign out_valid          = out_valid_q;
	assign residue            = residue_q;
	assign coded_value        = coded_q;
	assign end_of_message_out = eom_out_q;

`ifndef NO_ASSERTIONS
	a_idle_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !mm_rsp.busy)
		else $error("multiplier busy while taking a new item");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_RED_GO)
		else $error("accepted item did not start base reduction");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.done |-> (state_q == ST_RED_WAIT || state_q == ST_MUL_WAIT ||
			state_q == ST_SQ_WAIT))
		else $error("multiplier finished outside a wait state");

	a_product_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.done |-> {1'b0, mm_rsp.product} < n_ext)
		else $error("multiplier product not below modulus");
`endif

endmodule
